// File: rtl/status_led_breathing_sequencer_assert.svh
// Assertion macros shared by the status LED sequencer checkers.
`ifndef STATUS_LED_BREATHING_SEQUENCER_ASSERT_SVH
`define STATUS_LED_BREATHING_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on aclk and off while reset is held.
`define SLBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("status LED sequencer check failed");

// Next-cycle implication, sampled on aclk and off while reset is held.
`define SLBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("status LED sequencer check failed");

`endif

// File: rtl/slbs_pkg.sv
// Package with the item types, register indexes and constants of the LED sequencer.
`timescale 1ns / 1ps

package slbs_pkg;

    localparam int CfgDataWidth = 24;

    localparam logic CFG_STEP_PERIOD = 1'b0;
    localparam logic CFG_WIFI_COLOR  = 1'b1;

    localparam logic [15:0] STEP_PERIOD_RESET = 16'd20;
    localparam logic [23:0] WIFI_COLOR_RESET  = 24'hFFFF00;

    localparam logic [7:0] FADE_TOP  = 8'd255;
    localparam logic [7:0] FADE_STEP = 8'd5;

    localparam logic [23:0] COLOR_RED   = 24'hFF0000;
    localparam logic [23:0] COLOR_GREEN = 24'h00FF00;
    localparam logic [23:0] COLOR_BLUE  = 24'h0000FF;

    localparam logic [1:0] LEVEL_POWER    = 2'd0;
    localparam logic [1:0] LEVEL_WIFI     = 2'd1;
    localparam logic [1:0] LEVEL_INTERNET = 2'd2;
    localparam logic [1:0] LEVEL_CLOUD    = 2'd3;

    localparam logic [1:0] POWER_RED   = 2'd0;
    localparam logic [1:0] POWER_GREEN = 2'd1;
    localparam logic [1:0] POWER_BLUE  = 2'd2;

    typedef struct packed {
        logic wifi_connected;
        logic internet_live;
        logic cloud_registered;
    } slbs_in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] brightness;
        logic       write_strobe;
        logic [1:0] indicator_level;
        logic       fade_cycle_done;
    } slbs_out_t;

    // What the fade engine reports for the item now being processed.
    typedef struct packed {
        logic [7:0] brightness;
        logic       write_strobe;
        logic       fade_cycle_done;
    } slbs_fade_t;

endpackage

// File: rtl/status_led_breathing_sequencer.sv
// Top level of the status LED breathing sequencer.
`timescale 1ns / 1ps

// Each input item is one tick carrying the wifi, internet and cloud status
// flags. The block picks a status level (power, wifi, internet, cloud) and a
// colour for it, and runs one shared fade engine that steps brightness from
// 255 down to 0 and back up to 255 in steps of 5, one step each time
// step_period ticks have gone by (0 or 1 steps on every tick). In the power
// level the colour rotates red, green, blue, one full fade cycle each. Every
// item gives exactly one result with the colour, the brightness written
// (0 when no step was taken), the write strobe, the level and a flag on the
// step that ends a fade cycle. The block takes one item per clock cycle
// while results are taken; the item is registered on entry, the level
// decode and fade step are done between that register and the result
// register, and the fade state is updated in the same cycle the result
// is loaded, so the next item sees it at once. A stalled result holds
// the input stage, and the input is only blocked while both stages are
// full and the result is not being taken.
// Configuration registers are written through the cfg port, which is always
// ready; index 0 is step_period (reset 20) and index 1 is wifi_color
// (reset 0xFFFF00, red in the top byte). Write them only while no item is
// in flight.
module status_led_breathing_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  slbs_pkg::slbs_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output slbs_pkg::slbs_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_index,
    input  logic [slbs_pkg::CfgDataWidth-1:0]   cfg_data
);

    // Configuration registers.
    logic [15:0] step_period_reg;
    logic [23:0] wifi_color_reg;

    // Input stage and result stage of the two-register pipeline.
    logic                in_valid_reg;
    slbs_pkg::slbs_in_t  in_data_reg;
    logic                m_valid_reg;
    slbs_pkg::slbs_out_t m_data_reg, m_data_next;

    logic                 advance;
    logic                 fire;
    logic [1:0]           level;
    logic [23:0]          color;
    logic [1:0]           power_color_index;
    slbs_pkg::slbs_fade_t fade;

    // The result register can take a new item when empty or being drained.
    assign advance   = !m_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_period_reg <= slbs_pkg::STEP_PERIOD_RESET;
            wifi_color_reg  <= slbs_pkg::WIFI_COLOR_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                slbs_pkg::CFG_STEP_PERIOD: step_period_reg <= cfg_data[15:0];
                slbs_pkg::CFG_WIFI_COLOR:  wifi_color_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    slbs_color_sel u_color_sel (
        .item              (in_data_reg),
        .wifi_color        (wifi_color_reg),
        .power_color_index (power_color_index),
        .level             (level),
        .color             (color)
    );

    // The fade state only moves when the item in the input stage is passed on.
    slbs_fade_engine u_fade_engine (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .tick_en           (fire),
        .level             (level),
        .step_period       (step_period_reg),
        .power_color_index (power_color_index),
        .fade              (fade)
    );

    always_comb begin
        m_data_next.red             = color[23:16];
        m_data_next.green           = color[15:8];
        m_data_next.blue            = color[7:0];
        m_data_next.brightness      = fade.brightness;
        m_data_next.write_strobe    = fade.write_strobe;
        m_data_next.indicator_level = level;
        m_data_next.fade_cycle_done = fade.fade_cycle_done;
    end

    // Valid bits are reset; the payload registers load without reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/slbs_color_sel.sv
// Status level decode and colour selection for one item.
`timescale 1ns / 1ps

module slbs_color_sel (
    input  slbs_pkg::slbs_in_t item,
    input  logic [23:0]        wifi_color,
    input  logic [1:0]         power_color_index,
    output logic [1:0]         level,
    output logic [23:0]        color
);

    // Highest status that holds along the chain wins.
    always_comb begin
        if (!item.wifi_connected) begin
            level = slbs_pkg::LEVEL_POWER;
        end else if (!item.internet_live) begin
            level = slbs_pkg::LEVEL_WIFI;
        end else if (!item.cloud_registered) begin
            level = slbs_pkg::LEVEL_INTERNET;
        end else begin
            level = slbs_pkg::LEVEL_CLOUD;
        end
    end

    always_comb begin
        unique case (level)
            slbs_pkg::LEVEL_WIFI:     color = wifi_color;
            slbs_pkg::LEVEL_INTERNET: color = slbs_pkg::COLOR_BLUE;
            slbs_pkg::LEVEL_CLOUD:    color = slbs_pkg::COLOR_GREEN;
            default: begin
                // The unused power index shows red.
                case (power_color_index)
                    slbs_pkg::POWER_GREEN: color = slbs_pkg::COLOR_GREEN;
                    slbs_pkg::POWER_BLUE:  color = slbs_pkg::COLOR_BLUE;
                    default:               color = slbs_pkg::COLOR_RED;
                endcase
            end
        endcase
    end

endmodule

// File: rtl/slbs_fade_engine.sv
// Shared fade engine: tick timer, down/up brightness ramps and power colour index.
`timescale 1ns / 1ps

module slbs_fade_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick_en,
    input  logic [1:0]           level,
    input  logic [15:0]          step_period,
    output logic [1:0]           power_color_index,
    output slbs_pkg::slbs_fade_t fade
);

    logic [15:0] ticks_reg, ticks_next, ticks_inc;
    logic [7:0]  down_reg, down_next;
    logic [7:0]  up_reg, up_next;
    logic        phase_reg, phase_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic        step;

    always_comb begin
        ticks_inc  = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
        step       = (ticks_inc >= step_period);
        ticks_next = step ? 16'd0 : ticks_inc;
        down_next  = down_reg;
        up_next    = up_reg;
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        fade       = '0;

        if (step) begin
            fade.write_strobe = 1'b1;
            if (!phase_reg) begin
                fade.brightness = down_reg;
                if (down_reg < slbs_pkg::FADE_STEP) begin
                    down_next  = slbs_pkg::FADE_TOP;
                    phase_next = 1'b1;
                end else begin
                    down_next = down_reg - slbs_pkg::FADE_STEP;
                end
            end else begin
                fade.brightness = up_reg;
                if (up_reg > slbs_pkg::FADE_TOP - slbs_pkg::FADE_STEP) begin
                    up_next              = 8'd0;
                    phase_next           = 1'b0;
                    fade.fade_cycle_done = 1'b1;
                end else begin
                    up_next = up_reg + slbs_pkg::FADE_STEP;
                end
            end
        end

        if (fade.fade_cycle_done && level == slbs_pkg::LEVEL_POWER) begin
            pidx_next = (pidx_reg >= slbs_pkg::POWER_BLUE) ? slbs_pkg::POWER_RED
                                                           : pidx_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg <= '0;
            down_reg  <= slbs_pkg::FADE_TOP;
            up_reg    <= '0;
            phase_reg <= 1'b0;
            pidx_reg  <= slbs_pkg::POWER_RED;
        end else if (tick_en) begin
            ticks_reg <= ticks_next;
            down_reg  <= down_next;
            up_reg    <= up_next;
            phase_reg <= phase_next;
            pidx_reg  <= pidx_next;
        end
    end

    assign power_color_index = pidx_reg;

endmodule

// File: rtl/slbs_checker.sv
// Port-level checker for the status LED sequencer and its bind.
`timescale 1ns / 1ps
`include "status_led_breathing_sequencer_assert.svh"

module slbs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input slbs_pkg::slbs_out_t m_data
);

    // A stalled result holds.
    `SLBS_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data))

    // A cycle ends only on a strobed step that writes full brightness.
    `SLBS_ASSERT_NOW(a_done_on_top, m_valid && m_data.fade_cycle_done, m_data.write_strobe && m_data.brightness == slbs_pkg::FADE_TOP)

    // Without a step nothing is written.
    `SLBS_ASSERT_NOW(a_idle_dark, m_valid && !m_data.write_strobe, m_data.brightness == 8'd0 && !m_data.fade_cycle_done)

    // The power level always shows exactly one full primary colour.
    `SLBS_ASSERT_NOW(a_power_primary, m_valid && m_data.indicator_level == slbs_pkg::LEVEL_POWER, $onehot({m_data.red == 8'hFF, m_data.green == 8'hFF, m_data.blue == 8'hFF}) && $countones({m_data.red, m_data.green, m_data.blue}) == 8)

endmodule

bind status_led_breathing_sequencer slbs_checker u_slbs_checker (.*);
